// ===== rtl/core/gtrc_pkg.sv =====
package gtrc_pkg;

    localparam int SYMBOLS = 83;
    localparam int WORD_W = 64;
    localparam int IDX_W = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [7:0] RST_CHECK_START = 8'd78;

    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_LOAD_LO = 2'd0,
        KIND_LOAD_HI = 2'd1,
        KIND_CHAR    = 2'd2,
        KIND_REPORT  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_GATE      = 3'd1,
        ST_BAD_CHAR  = 3'd2,
        ST_BAD_COUNT = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_UNTERM    = 3'd5,
        ST_REPORT    = 3'd6,
        ST_IGNORED   = 3'd7
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET      = 1'b0,
        CFG_CHECK_START = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic ld_lo;
        logic ld_hi;
        logic gate;
        logic report;
    } t_op;

    typedef struct packed {
        logic       ok;
        logic [6:0] code;
    } t_sym;

    // 0-9, a-z, A-Z, then the punctuation marks !@#$%^&*()-_=+[]{}<>? in that order
    function automatic t_sym sym_of(input logic [7:0] ch);
        t_sym s;
        s.ok = 1'b1;
        s.code = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            s.code = 7'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            s.code = 7'(ch - 8'h61 + 8'd10);
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            s.code = 7'(ch - 8'h41 + 8'd36);
        end else begin
            case (ch)
                8'h21: s.code = 7'd62;
                8'h40: s.code = 7'd63;
                8'h23: s.code = 7'd64;
                8'h24: s.code = 7'd65;
                8'h25: s.code = 7'd66;
                8'h5E: s.code = 7'd67;
                8'h26: s.code = 7'd68;
                8'h2A: s.code = 7'd69;
                8'h28: s.code = 7'd70;
                8'h29: s.code = 7'd71;
                8'h2D: s.code = 7'd72;
                8'h5F: s.code = 7'd73;
                8'h3D: s.code = 7'd74;
                8'h2B: s.code = 7'd75;
                8'h5B: s.code = 7'd76;
                8'h5D: s.code = 7'd77;
                8'h7B: s.code = 7'd78;
                8'h7D: s.code = 7'd79;
                8'h3C: s.code = 7'd80;
                8'h3E: s.code = 7'd81;
                8'h3F: s.code = 7'd82;
                default: s.ok = 1'b0;
            endcase
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/gtrc_parse.sv =====
module gtrc_parse #(
    parameter int STATE_BITS = 128,
    parameter int IW = $clog2(STATE_BITS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_char_code,
    output gtrc_pkg::t_op       o_op,
    output gtrc_pkg::t_status   o_status,
    output logic [IW-1:0]       o_wire_a,
    output logic [IW-1:0]       o_wire_b,
    output logic [IW-1:0]       o_wire_c
);
    import gtrc_pkg::*;

    logic [2:0]    r_wc, n_wc;
    logic [1:0]    r_ovf, n_ovf;
    logic          r_err, n_err;
    logic [IW-1:0] r_pend [3];
    logic          pend_we;
    t_sym          sym;
    logic [IDX_W-1:0] idx;
    t_kind         kind;

    assign kind = t_kind'(i_kind);
    assign sym = sym_of(i_char_code);
    assign idx = IDX_W'(sym.code) + IDX_W'(SYMBOLS) * IDX_W'(r_ovf);

    always_comb begin
        n_wc = r_wc;
        n_ovf = r_ovf;
        n_err = r_err;
        pend_we = 1'b0;
        o_status = ST_OK;
        o_op = '0;
        case (kind)
            KIND_LOAD_LO, KIND_LOAD_HI: begin
                o_op.ld_lo = (kind == KIND_LOAD_LO);
                o_op.ld_hi = (kind == KIND_LOAD_HI);
                n_wc = '0;
                n_ovf = '0;
                n_err = 1'b0;
            end
            KIND_CHAR: begin
                if (r_err) begin
                    o_status = ST_IGNORED;
                end else if (i_char_code == CH_SEMI) begin
                    n_wc = '0;
                    n_ovf = '0;
                    if (r_wc == 3'd0) begin
                        o_status = ST_OK;
                    end else if (r_wc != 3'd3) begin
                        n_err = 1'b1;
                        o_status = ST_BAD_COUNT;
                    end else begin
                        o_op.gate = 1'b1;
                        o_status = ST_GATE;
                    end
                end else if (i_char_code == CH_TILDE) begin
                    if (r_ovf != 2'd3) begin
                        n_ovf = r_ovf + 2'd1;
                    end
                end else if (i_char_code == CH_LF || i_char_code == CH_CR ||
                             i_char_code == CH_TAB || i_char_code == CH_SPACE) begin
                    o_status = ST_OK;
                end else if (!sym.ok) begin
                    n_err = 1'b1;
                    o_status = ST_BAD_CHAR;
                end else begin
                    n_ovf = '0;
                    if (r_wc < 3'd3 && 32'(idx) >= STATE_BITS) begin
                        n_err = 1'b1;
                        o_status = ST_BAD_INDEX;
                    end else begin
                        pend_we = (r_wc < 3'd3);
                        if (r_wc != 3'd7) begin
                            n_wc = r_wc + 3'd1;
                        end
                    end
                end
            end
            KIND_REPORT: begin
                if (!r_err && r_wc != 3'd0) begin
                    n_err = 1'b1;
                    o_status = ST_UNTERM;
                end else begin
                    o_status = ST_REPORT;
                    o_op.report = !r_err;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
            r_ovf <= '0;
            r_err <= 1'b0;
        end else if (i_acc) begin
            r_wc <= n_wc;
            r_ovf <= n_ovf;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && pend_we) begin
            r_pend[r_wc[1:0]] <= IW'(idx);
        end
    end

    assign o_wire_a = r_pend[0];
    assign o_wire_b = r_pend[1];
    assign o_wire_c = r_pend[2];

endmodule

// ===== rtl/core/gtrc_state.sv =====
module gtrc_state #(
    parameter int STATE_BITS = 128,
    parameter int IW = $clog2(STATE_BITS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  gtrc_pkg::t_op       i_op,
    input  logic [63:0]         i_state_word,
    input  logic [IW-1:0]       i_wire_a,
    input  logic [IW-1:0]       i_wire_b,
    input  logic [IW-1:0]       i_wire_c,
    input  logic [63:0]         i_target,
    input  logic [7:0]          i_check_start,
    output logic [63:0]         o_state_low,
    output logic [63:0]         o_state_high,
    output logic                o_target_match,
    output logic                o_upper_clear
);
    import gtrc_pkg::*;

    localparam int PADW = (STATE_BITS > 2 * WORD_W) ? STATE_BITS : 2 * WORD_W;

    logic [STATE_BITS-1:0] r_state, n_state;
    logic [PADW-1:0]       cur_pad, ld_pad, nxt_pad;
    logic [STATE_BITS-1:0] hit;
    logic                  flip;

    assign cur_pad = PADW'(r_state);
    assign flip = r_state[i_wire_b] | ~r_state[i_wire_c];

    always_comb begin
        ld_pad = cur_pad;
        if (i_op.ld_lo) begin
            ld_pad[WORD_W-1:0] = i_state_word;
        end
        if (i_op.ld_hi) begin
            ld_pad[2*WORD_W-1:WORD_W] = i_state_word;
        end
        n_state = ld_pad[STATE_BITS-1:0];
        if (i_op.gate && flip) begin
            n_state[i_wire_a] = ~r_state[i_wire_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_acc) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        for (int i = 0; i < STATE_BITS; i++) begin
            hit[i] = r_state[i] && (i >= int'(i_check_start));
        end
    end

    assign nxt_pad = PADW'(n_state);
    assign o_state_low = nxt_pad[WORD_W-1:0];
    assign o_state_high = nxt_pad[2*WORD_W-1:WORD_W];
    assign o_target_match = i_op.report && (cur_pad[WORD_W-1:0] == i_target);
    assign o_upper_clear = i_op.report && (hit == '0);

endmodule

// ===== rtl/core/gate_text_reversible_circuit_eval_top.sv =====
// Channel   Direction  Handshake                  Beat contents
// in        sink       i_in_valid / o_in_stall    i_kind, i_state_word, i_char_code
// out       source     o_out_valid / i_out_stall  o_status, o_state_low, o_state_high,
//                                                 o_target_match, o_upper_clear
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat per cycle unless stalled; results come out in the cycle after acceptance.
// The whole item (decode, parse, gate update, flags) is one combinational pass
// into the wire register, the state register and the output register.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// The input stalls only while the output register is full and stalled.
module gate_text_reversible_circuit_eval_top #(
    parameter int STATE_BITS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [63:0]                    i_state_word,
    input  logic [7:0]                     i_char_code,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [63:0]                    o_state_low,
    output logic [63:0]                    o_state_high,
    output logic                           o_target_match,
    output logic                           o_upper_clear,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gtrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import gtrc_pkg::*;

    localparam int IW = $clog2(STATE_BITS);

    logic          acc;
    t_op           op;
    t_status       status;
    logic [IW-1:0] wire_a, wire_b, wire_c;
    logic [63:0]   st_low, st_high;
    logic          match, clear;

    logic [63:0]   r_target;
    logic [7:0]    r_start;
    logic          r_ov;
    logic [2:0]    r_status;
    logic [63:0]   r_low, r_high;
    logic          r_match, r_clear;

    assign o_in_stall = r_ov & i_out_stall;
    assign acc = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_start <= RST_CHECK_START;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET:      r_target <= i_cfg_data;
                CFG_CHECK_START: r_start <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    gtrc_parse #(
        .STATE_BITS(STATE_BITS),
        .IW(IW)
    ) u_parse (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_acc(acc),
        .i_kind(i_kind),
        .i_char_code(i_char_code),
        .o_op(op),
        .o_status(status),
        .o_wire_a(wire_a),
        .o_wire_b(wire_b),
        .o_wire_c(wire_c)
    );

    gtrc_state #(
        .STATE_BITS(STATE_BITS),
        .IW(IW)
    ) u_state (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_acc(acc),
        .i_op(op),
        .i_state_word(i_state_word),
        .i_wire_a(wire_a),
        .i_wire_b(wire_b),
        .i_wire_c(wire_c),
        .i_target(r_target),
        .i_check_start(r_start),
        .o_state_low(st_low),
        .o_state_high(st_high),
        .o_target_match(match),
        .o_upper_clear(clear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (acc) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= status;
            r_low <= st_low;
            r_high <= st_high;
            r_match <= match;
            r_clear <= clear;
        end
    end

    assign o_out_valid = r_ov;
    assign o_status = r_status;
    assign o_state_low = r_low;
    assign o_state_high = r_high;
    assign o_target_match = r_match;
    assign o_upper_clear = r_clear;

endmodule

// ===== rtl/core/gtrc_checker.sv =====
module gtrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_kind,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic        o_target_match,
    input logic        o_upper_clear
);
    import gtrc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("result beat dropped or changed under stall");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output can move");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_target_match || o_upper_clear) |-> o_status == ST_REPORT)
        else $error("report flags on a non-report beat");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_kind == KIND_LOAD_LO || i_kind == KIND_LOAD_HI) |=> o_status == ST_OK)
        else $error("load beat returned a non-ok status");

endmodule

bind gate_text_reversible_circuit_eval_top gtrc_checker u_gtrc_checker (.*);

// ===== tb/sv/gate_text_reversible_circuit_eval_top_test.sv =====
module gate_text_reversible_circuit_eval_top_test;
    import gtrc_pkg::*;

    localparam int WIRES = 128;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_PRINTS = 60;

    typedef struct packed {
        t_status     status;
        logic [63:0] low;
        logic [63:0] high;
        logic        match;
        logic        clear;
    } t_gate_answer;

    typedef struct {
        t_kind       kind;
        logic [63:0] word;
        logic [7:0]  ch;
        bit          typed;
        t_status     st;
    } t_text_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_kind = KIND_LOAD_LO;
    logic [63:0]          i_state_word = '0;
    logic [7:0]           i_char_code = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [63:0]          o_state_low;
    logic [63:0]          o_state_high;
    logic                 o_target_match;
    logic                 o_upper_clear;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TARGET;
    logic [63:0]          i_cfg_data = '0;

    // predicted block state
    logic [WIRES-1:0] wires_now = '0;
    logic [6:0]       pend_wires [3];
    int unsigned      wire_cnt = 0;
    int unsigned      tilde_cnt = 0;
    bit               fault_latched = 1'b0;
    logic [63:0]      cfg_target = '0;
    logic [7:0]       cfg_start = RST_CHECK_START;

    string       symbol_set = {"0123456789abcdefghijklmnopqrstuvwxyz",
                               "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()-_=+[]{}<>?"};
    logic [7:0]  blank_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    t_gate_answer circuit_answers [$];
    t_text_row    script [$];

    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    int stall_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int gates_applied = 0;
    int reports_done = 0;
    int target_hits = 0;
    int clear_hits = 0;
    int error_beats = 0;
    int cfg_writes = 0;

    gate_text_reversible_circuit_eval_top #(
        .STATE_BITS(WIRES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_state_word  (i_state_word),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_state_low   (o_state_low),
        .o_state_high  (o_state_high),
        .o_target_match(o_target_match),
        .o_upper_clear (o_upper_clear),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("timeout: %0d results still pending", circuit_answers.size());
        $display("** gate_text_reversible_circuit_eval_top: FAILED **");
        $finish;
    end

    function automatic int symbol_index(input logic [7:0] ch);
        int i;
        for (i = 0; i < SYMBOLS; i++) begin
            if (symbol_set[i] == ch) return i;
        end
        return -1;
    endfunction

    task automatic step_circuit(input t_kind k, input logic [63:0] w, input logic [7:0] c,
                                output t_gate_answer ans);
        t_status     st;
        logic        hit;
        logic        clr;
        int unsigned n;
        int          sym;
        int unsigned idx;
        st = ST_OK;
        hit = 1'b0;
        clr = 1'b0;
        case (k)
            KIND_LOAD_LO, KIND_LOAD_HI: begin
                if (k == KIND_LOAD_LO) wires_now[63:0] = w;
                else wires_now[127:64] = w;
                wire_cnt = 0;
                tilde_cnt = 0;
                fault_latched = 1'b0;
            end
            KIND_CHAR: begin
                if (fault_latched) begin
                    st = ST_IGNORED;
                end else if (c == CH_SEMI) begin
                    n = wire_cnt;
                    tilde_cnt = 0;
                    wire_cnt = 0;
                    if (n == 3) begin
                        if (wires_now[pend_wires[1]] | ~wires_now[pend_wires[2]])
                            wires_now[pend_wires[0]] = ~wires_now[pend_wires[0]];
                        st = ST_GATE;
                    end else if (n != 0) begin
                        fault_latched = 1'b1;
                        st = ST_BAD_COUNT;
                    end
                end else if (c == CH_TILDE) begin
                    if (tilde_cnt < 3) tilde_cnt++;
                end else if (c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_SPACE) begin
                    st = ST_OK;
                end else begin
                    sym = symbol_index(c);
                    if (sym < 0) begin
                        fault_latched = 1'b1;
                        st = ST_BAD_CHAR;
                    end else begin
                        idx = sym + SYMBOLS * tilde_cnt;
                        tilde_cnt = 0;
                        if (wire_cnt < 3 && idx >= WIRES) begin
                            fault_latched = 1'b1;
                            st = ST_BAD_INDEX;
                        end else begin
                            if (wire_cnt < 3) pend_wires[wire_cnt] = idx[6:0];
                            if (wire_cnt < 7) wire_cnt++;
                        end
                    end
                end
            end
            default: begin
                if (!fault_latched && wire_cnt != 0) begin
                    fault_latched = 1'b1;
                    st = ST_UNTERM;
                end else begin
                    st = ST_REPORT;
                    if (!fault_latched) begin
                        hit = (wires_now[63:0] == cfg_target);
                        clr = (cfg_start >= WIRES) ? 1'b1 : ((wires_now >> cfg_start) == '0);
                    end
                end
            end
        endcase
        if (st == ST_GATE) gates_applied++;
        if (st == ST_REPORT) reports_done++;
        if (st >= ST_BAD_CHAR && st <= ST_UNTERM) error_beats++;
        target_hits += hit;
        clear_hits += clr;
        ans = '{st, wires_now[63:0], wires_now[127:64], hit, clr};
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
            $display("mismatch at %0t, result %0d: %s", $realtime, results_seen, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic send_beat(input t_kind k, input logic [63:0] w, input logic [7:0] c,
                             input bit typed = 1'b0, input t_status typed_st = ST_OK);
        t_gate_answer ans;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= k;
        i_state_word <= w;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        step_circuit(k, w, c, ans);
        if (typed) ans.status = typed_st;
        circuit_answers.insert(circuit_answers.size(), ans);
        if (ans.status != ST_IGNORED) items_sent++;
    endtask

    task automatic add_row(input t_kind k, input logic [63:0] w, input logic [7:0] c,
                           input bit typed, input t_status st);
        t_text_row r;
        r.kind = k;
        r.word = w;
        r.ch = c;
        r.typed = typed;
        r.st = st;
        script.insert(script.size(), r);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (circuit_answers.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] tgt, input logic [7:0] start);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TARGET;
        i_cfg_data <= tgt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_target = tgt;
        i_cfg_index <= CFG_CHECK_START;
        i_cfg_data <= {56'd0, start};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_start = start;
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // nw wires, optionally one out of range, optionally closed by ';'
    task automatic send_gate_text(input int nw, input bit oversize, input bit close);
        int k;
        int idx;
        int bad_at;
        bad_at = oversize ? $urandom_range(0, 2) : -1;
        for (k = 0; k < nw; k++) begin
            if (k == bad_at) idx = $urandom_range(WIRES, 4 * SYMBOLS - 1);
            else idx = $urandom_range(0, WIRES - 1);
            if ($urandom_range(0, 7) == 0)
                send_beat(KIND_CHAR, {$urandom, $urandom}, blank_chars[$urandom_range(0, 3)]);
            repeat (idx / SYMBOLS) send_beat(KIND_CHAR, {$urandom, $urandom}, CH_TILDE);
            if (idx / SYMBOLS == 3 && $urandom_range(0, 1) == 0)
                send_beat(KIND_CHAR, {$urandom, $urandom}, CH_TILDE);
            send_beat(KIND_CHAR, {$urandom, $urandom}, symbol_set[idx % SYMBOLS]);
        end
        if (close) send_beat(KIND_CHAR, {$urandom, $urandom}, CH_SEMI);
    endtask

    task automatic random_chunk();
        int          pick;
        int          nw;
        logic [63:0] w;
        pick = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        if (fault_latched && pick < 75) begin
            send_beat(pick[0] ? KIND_LOAD_HI : KIND_LOAD_LO, w, 8'($urandom));
        end else if (pick < 8) begin
            case ($urandom_range(0, 3))
                0: w = '0;
                1: w = '1;
                2: w = cfg_target;
                default: ;
            endcase
            send_beat(KIND_LOAD_LO, w, 8'($urandom));
        end else if (pick < 14) begin
            case ($urandom_range(0, 3))
                0: w = '0;
                1: w = w & 64'h3FFF;
                2: w = '1;
                default: ;
            endcase
            send_beat(KIND_LOAD_HI, w, 8'($urandom));
        end else if (pick < 64) begin
            send_gate_text(3, 1'b0, 1'b1);
        end else if (pick < 74) begin
            send_beat(KIND_REPORT, w, 8'($urandom));
        end else if (pick < 80) begin
            nw = $urandom_range(1, 6);
            if (nw >= 3) nw++;
            send_gate_text(nw, 1'b0, 1'b1);
        end else if (pick < 84) begin
            send_gate_text(3, 1'b1, 1'b1);
        end else if (pick < 89) begin
            send_beat(KIND_CHAR, w, 8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
            send_beat(KIND_CHAR, w, CH_SEMI);
        end else if (pick < 96) begin
            send_gate_text($urandom_range(1, 3), 1'b0, 1'b0);
            send_beat(KIND_REPORT, {$urandom, $urandom}, 8'($urandom));
        end else begin
            send_beat(t_kind'($urandom_range(0, 3)), w, 8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin : result_side
        t_gate_answer want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (circuit_answers.size() == 0) begin
                    report_mismatch("result beat with no item pending");
                end else begin
                    want = circuit_answers.pop_front();
                    compare_field("status", 64'(o_status), 64'(want.status));
                    compare_field("state_low", o_state_low, want.low);
                    compare_field("state_high", o_state_high, want.high);
                    compare_field("target_match", 64'(o_target_match), 64'(want.match));
                    compare_field("upper_clear", 64'(o_upper_clear), 64'(want.clear));
                end
            end
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                i_out_stall <= 1'b1;
            end else if (!idle_on) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int          ph;
        int          goal;
        logic [63:0] tgt;
        logic [7:0]  start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(KIND_REPORT,  '0, '0, 1'b1, ST_REPORT);
        add_row(KIND_LOAD_LO, '1, '0, 1'b1, ST_OK);
        add_row(KIND_LOAD_HI, '1, '0, 1'b1, ST_OK);
        add_row(KIND_CHAR,    '0, "0", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, CH_TAB, 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "a", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "?", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, CH_SEMI, 1'b1, ST_GATE);
        add_row(KIND_CHAR,    '0, CH_SEMI, 1'b1, ST_OK);
        repeat (4) add_row(KIND_CHAR, '0, CH_TILDE, 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "z", 1'b1, ST_BAD_INDEX);
        add_row(KIND_CHAR,    '0, "x", 1'b1, ST_IGNORED);
        add_row(KIND_REPORT,  '0, '0, 1'b1, ST_REPORT);
        add_row(KIND_LOAD_LO, '0, '0, 1'b1, ST_OK);
        add_row(KIND_CHAR,    '0, CH_TILDE, 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "I", 1'b0, ST_OK);
        add_row(KIND_REPORT,  '0, '0, 1'b1, ST_UNTERM);
        add_row(KIND_LOAD_LO, 64'h0123_4567_89AB_CDEF, '0, 1'b1, ST_OK);
        add_row(KIND_CHAR,    '0, 8'hFF, 1'b1, ST_BAD_CHAR);
        add_row(KIND_LOAD_HI, '0, '0, 1'b1, ST_OK);
        add_row(KIND_CHAR,    '0, "1", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "2", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "3", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, "4", 1'b0, ST_OK);
        add_row(KIND_CHAR,    '0, CH_SEMI, 1'b1, ST_BAD_COUNT);
        add_row(KIND_REPORT,  '0, '0, 1'b1, ST_REPORT);
        foreach (script[i])
            send_beat(script[i].kind, script[i].word, script[i].ch,
                      script[i].typed, script[i].st);

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin tgt = {$urandom, $urandom}; start = 8'd0; end
                1: begin tgt = '1; start = 8'd128; end
                2: begin tgt = wires_now[63:0]; start = 8'd64; end
                3: begin tgt = '0; start = 8'd127; end
                4: begin tgt = wires_now[63:0]; start = 8'($urandom_range(0, 128)); end
                default: begin tgt = {$urandom, $urandom}; start = RST_CHECK_START; end
            endcase
            set_config(tgt, start);
            idle_on <= (ph < 5);
            goal = items_sent + 140;
            while (items_sent < goal) begin
                // long output hold-off while beats keep coming
                if (ph == 1 && items_sent + 100 >= goal) hold_req <= 1'b1;
                random_chunk();
            end
        end
        settle();

        $display("%0d items: %0d gates applied, %0d reports (%0d target hits, %0d clear),",
                 items_sent, gates_applied, reports_done, target_hits, clear_hits);
        $display("%0d errors, %0d result beats checked, %0d register writes, %0d mismatches",
                 error_beats, results_seen, cfg_writes, errors);
        if (errors == 0) begin
            $display("** gate_text_reversible_circuit_eval_top: PASSED **");
        end else begin
            $display("** gate_text_reversible_circuit_eval_top: FAILED **");
        end
        $finish;
    end

endmodule
